// ----- hdl/tdc_pkg.sv -----
`default_nettype none
package tdc_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_COLOR_RED     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_COLOR_GREEN   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_COLOR_BLUE    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RAMP_STEP     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_RAMP_INTERVAL = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_FADE_INTERVAL = 3'd6;

	localparam logic [2:0] MODE_OFF      = 3'd0;
	localparam logic [2:0] MODE_FADE_ON  = 3'd1;
	localparam logic [2:0] MODE_ON       = 3'd2;
	localparam logic [2:0] MODE_FADE_OFF = 3'd3;
	localparam logic [2:0] MODE_BRIGHTER = 3'd4;

	localparam logic [6:0] LEVEL_MAX = 7'd100;

	// floor(x / 100) == (x * 5243) >> 19 for x <= 255 * 100
	localparam logic [19:0] RECIP_100  = 20'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	typedef struct packed {
		logic [15:0] hold_ticks;
		logic [7:0]  color_red;
		logic [7:0]  color_green;
		logic [7:0]  color_blue;
		logic [6:0]  ramp_step;
		logic [9:0]  ramp_interval;
		logic [7:0]  fade_interval;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [6:0] level;
		logic [2:0] mode;
	} stage_t;

endpackage
`default_nettype wire

// ----- hdl/tdc_if.sv -----
`default_nettype none
interface tdc_in_if;
	logic valid;
	logic ready;
	logic touch;
	modport source (output valid, output touch, input ready);
	modport sink (input valid, input touch, output ready);
endinterface

interface tdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [6:0] level_out;
	logic [2:0] mode_out;
	modport source (output valid, output red_out, output green_out, output blue_out,
		output level_out, output mode_out, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input level_out, input mode_out, output ready);
endinterface

interface tdc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tdc_pkg::CFG_ADDR_W-1:0] addr;
	logic [tdc_pkg::CFG_DATA_W-1:0] wdata;
	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface
`default_nettype wire

// ----- hdl/touch_dimmer_controller_top.sv -----
// Touch dimmer controller.
// tick:   one transfer per millisecond tick, carrying the sampled touch level.
// result: one transfer per tick with the scaled red/green/blue drive values,
//         the shown level in percent and the lamp mode.
// cfg:    register writes (addr 0..6: hold ticks, red, green, blue, ramp
//         step, ramp interval, fade interval); always ready. Write only while
//         no tick is in flight.
// The lamp state is updated in the cycle a tick is taken; its result passes
// through the state stage, the level factor stage and the color multiply
// stage. One tick per cycle is sustained while result.ready is high.
// When result.ready is low and the result register is full, the whole
// pipeline holds and tick.ready drops; nothing is lost or repeated.
// Reset clears the pipeline and puts the lamp off with set level 100 and the
// registers at their defaults.
`default_nettype none
module touch_dimmer_controller_top (
	input  wire       clk,
	input  wire       arst_n,
	tdc_in_if.sink    tick,
	tdc_out_if.source result,
	tdc_cfg_if.sink   cfg
);
	import tdc_pkg::*;

	cfg_t   regs;
	stage_t st_s1;
	logic   adv;
	logic   accept;

	assign adv        = !result.valid || result.ready;
	assign tick.ready = adv;
	assign accept     = tick.valid && adv;

	tdc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tdc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.accept (accept),
		.touch  (tick.touch),
		.regs   (regs),
		.st_s1  (st_s1)
	);

	tdc_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.st_s1  (st_s1),
		.regs   (regs),
		.result (result)
	);
endmodule
`default_nettype wire

// ----- hdl/tdc_cfg.sv -----
`default_nettype none
module tdc_cfg (
	input  wire         clk,
	input  wire         arst_n,
	tdc_cfg_if.sink     cfg,
	output tdc_pkg::cfg_t regs
);
	import tdc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hold_ticks    <= 16'd2000;
			regs_q.color_red     <= 8'd255;
			regs_q.color_green   <= 8'd100;
			regs_q.color_blue    <= 8'd0;
			regs_q.ramp_step     <= 7'd5;
			regs_q.ramp_interval <= 10'd100;
			regs_q.fade_interval <= 8'd2;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_HOLD_TICKS:    regs_q.hold_ticks    <= cfg.wdata;
				REG_COLOR_RED:     regs_q.color_red     <= cfg.wdata[7:0];
				REG_COLOR_GREEN:   regs_q.color_green   <= cfg.wdata[7:0];
				REG_COLOR_BLUE:    regs_q.color_blue    <= cfg.wdata[7:0];
				REG_RAMP_STEP:     regs_q.ramp_step     <= cfg.wdata[6:0];
				REG_RAMP_INTERVAL: regs_q.ramp_interval <= cfg.wdata[9:0];
				REG_FADE_INTERVAL: regs_q.fade_interval <= cfg.wdata[7:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/tdc_state.sv -----
`default_nettype none
module tdc_state (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            adv,
	input  wire            accept,
	input  wire            touch,
	input  tdc_pkg::cfg_t  regs,
	output tdc_pkg::stage_t st_s1
);
	import tdc_pkg::*;

	logic [2:0]  mode_q;
	logic [6:0]  set_level_q;
	logic [6:0]  fade_level_q;
	logic        last_touch_q;
	logic [15:0] press_ticks_q;
	logic        press_active_q;
	logic [9:0]  step_timer_q;
	stage_t      st_s1_q;

	logic [2:0]  mode_d;
	logic [6:0]  set_level_d;
	logic [6:0]  fade_level_d;
	logic [15:0] press_ticks_d;
	logic        press_active_d;
	logic [9:0]  step_timer_d;
	logic [9:0]  timer_inc;
	logic [7:0]  bright_sum;
	logic        rising;
	logic        falling;
	logic        long_press;
	logic [6:0]  level_d;

	assign st_s1 = st_s1_q;

	always_comb begin
		mode_d         = mode_q;
		set_level_d    = set_level_q;
		fade_level_d   = fade_level_q;
		press_ticks_d  = press_ticks_q;
		press_active_d = press_active_q;
		step_timer_d   = step_timer_q;
		timer_inc      = step_timer_q + 10'd1;
		rising         = touch && !last_touch_q;
		falling        = !touch && last_touch_q;
		bright_sum     = 8'd0;
		level_d        = 7'd0;

		case (mode_q)
			MODE_FADE_ON, MODE_FADE_OFF: begin
				step_timer_d = timer_inc;
				if (timer_inc >= {2'b00, regs.fade_interval}) begin
					step_timer_d = 10'd0;
					if (mode_q == MODE_FADE_ON) begin
						if (fade_level_q < LEVEL_MAX)
							fade_level_d = fade_level_q + 7'd1;
						if (fade_level_d >= set_level_q)
							mode_d = MODE_ON;
					end else begin
						if (fade_level_q != 7'd0)
							fade_level_d = fade_level_q - 7'd1;
						if (fade_level_d == 7'd0)
							mode_d = MODE_OFF;
					end
				end
			end
			MODE_BRIGHTER: begin
				step_timer_d = timer_inc;
				if (timer_inc >= regs.ramp_interval) begin
					step_timer_d = 10'd0;
					bright_sum   = {1'b0, set_level_q} + {1'b0, regs.ramp_step};
					set_level_d  = (bright_sum > {1'b0, LEVEL_MAX}) ? 7'd0 : bright_sum[6:0];
				end
			end
			default: ;
		endcase

		if (rising) begin
			press_active_d = 1'b1;
			press_ticks_d  = 16'd0;
		end else if (press_active_q && press_ticks_q != 16'hFFFF) begin
			press_ticks_d = press_ticks_q + 16'd1;
		end

		long_press = press_ticks_d >= regs.hold_ticks;

		if (falling && press_active_d) begin
			if (mode_d == MODE_BRIGHTER || long_press) begin
				mode_d = MODE_ON;
			end else if (mode_d == MODE_OFF) begin
				mode_d       = MODE_FADE_ON;
				fade_level_d = 7'd0;
				step_timer_d = 10'd0;
			end else if (mode_d == MODE_ON) begin
				mode_d       = MODE_FADE_OFF;
				fade_level_d = set_level_d;
				step_timer_d = 10'd0;
			end
			press_active_d = 1'b0;
			press_ticks_d  = 16'd0;
		end else if (press_active_d && touch && mode_d == MODE_ON && long_press) begin
			mode_d       = MODE_BRIGHTER;
			step_timer_d = 10'd0;
			bright_sum   = {1'b0, set_level_d} + {1'b0, regs.ramp_step};
			set_level_d  = (bright_sum > {1'b0, LEVEL_MAX}) ? 7'd0 : bright_sum[6:0];
		end

		case (mode_d)
			MODE_FADE_ON, MODE_FADE_OFF: level_d = fade_level_d;
			MODE_ON, MODE_BRIGHTER:      level_d = set_level_d;
			default:                     level_d = 7'd0;
		endcase
		if (level_d > LEVEL_MAX)
			level_d = LEVEL_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_OFF;
			set_level_q    <= LEVEL_MAX;
			fade_level_q   <= 7'd0;
			last_touch_q   <= 1'b0;
			press_ticks_q  <= 16'd0;
			press_active_q <= 1'b0;
			step_timer_q   <= 10'd0;
			st_s1_q        <= '0;
		end else begin
			if (accept) begin
				mode_q         <= mode_d;
				set_level_q    <= set_level_d;
				fade_level_q   <= fade_level_d;
				last_touch_q   <= touch;
				press_ticks_q  <= press_ticks_d;
				press_active_q <= press_active_d;
				step_timer_q   <= step_timer_d;
				st_s1_q.level  <= level_d;
				st_s1_q.mode   <= mode_d;
			end
			if (adv)
				st_s1_q.valid <= accept;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/tdc_scale.sv -----
`default_nettype none
module tdc_scale (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             adv,
	input  tdc_pkg::stage_t st_s1,
	input  tdc_pkg::cfg_t   regs,
	tdc_out_if.source       result
);
	import tdc_pkg::*;

	stage_t      st_s2;
	logic [19:0] factor_s2;
	logic        valid_s3;
	logic [7:0]  red_s3;
	logic [7:0]  green_s3;
	logic [7:0]  blue_s3;
	logic [6:0]  level_s3;
	logic [2:0]  mode_s3;
	logic [27:0] red_prod;
	logic [27:0] green_prod;
	logic [27:0] blue_prod;

	assign red_prod   = {20'd0, regs.color_red}   * {8'd0, factor_s2};
	assign green_prod = {20'd0, regs.color_green} * {8'd0, factor_s2};
	assign blue_prod  = {20'd0, regs.color_blue}  * {8'd0, factor_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2    <= '0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			st_s2    <= st_s1;
			valid_s3 <= st_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			factor_s2   <= {13'd0, st_s1.level} * RECIP_100;
			red_s3      <= red_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			green_s3    <= green_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			blue_s3     <= blue_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			level_s3    <= st_s2.level;
			mode_s3     <= st_s2.mode;
		end
	end

	assign result.valid     = valid_s3;
	assign result.red_out   = red_s3;
	assign result.green_out = green_s3;
	assign result.blue_out  = blue_s3;
	assign result.level_out = level_s3;
	assign result.mode_out  = mode_s3;
endmodule
`default_nettype wire
